/* rtl/nnsg_pkg.sv */
// ============================================================================
// nnsg_pkg: shared types and constants for the scale-to-glyph-level unit
// Command and result transfer types, the configuration bundle, register
// indexes and reset values.
// ============================================================================
`default_nettype none

package nnsg_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_W      = 9;

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_GLYPH_LEVELS = 3'd4;

    // Reset values of the registers
    localparam logic [REG_W-1:0] RST_SRC_WIDTH    = 9'd64;
    localparam logic [REG_W-1:0] RST_SRC_HEIGHT   = 9'd64;
    localparam logic [REG_W-1:0] RST_OUT_WIDTH    = 9'd64;
    localparam logic [REG_W-1:0] RST_OUT_HEIGHT   = 9'd64;
    localparam logic [REG_W-1:0] RST_GLYPH_LEVELS = 9'd10;

    // Largest number of brightness levels
    localparam logic [REG_W-1:0] LEVEL_LIMIT = 9'd256;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pixel_in;
    } nnsg_item_t;

    typedef struct packed {
        logic [7:0] sample;
        logic [7:0] level_index;
        logic       range_error;
    } nnsg_result_t;

    typedef struct packed {
        logic [REG_W-1:0] src_width;
        logic [REG_W-1:0] src_height;
        logic [REG_W-1:0] out_width;
        logic [REG_W-1:0] out_height;
        logic [REG_W-1:0] glyph_levels;
    } nnsg_cfg_t;

endpackage

`default_nettype wire

/* rtl/nnsg_ram.sv */
// ============================================================================
// nnsg_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module nnsg_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/nnsg_divider.sv */
// ============================================================================
// nnsg_divider: bit-serial restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits in QUO_W bits, so only QUO_W steps are run.
// ============================================================================
`default_nettype none

module nnsg_divider #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 9,
    parameter int QUO_W = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [QUO_W-1:0] shift_reg, shift_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {rem_reg, shift_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        shift_next  = shift_reg;
        if (start)
        begin
            // The high part of the dividend is already below the divisor.
            active_next = 1'b1;
            cnt_next    = CNT_W'(QUO_W);
            rem_next    = DVS_W'(dividend >> QUO_W);
            dvs_next    = divisor;
            shift_next  = dividend[QUO_W-1:0];
        end
        else if (active_reg)
        begin
            rem_next   = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            shift_next = QUO_W'({shift_reg, fits});
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Datapath registers; the shift register collects the quotient bits.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        shift_reg <= shift_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

/* rtl/nnsg_regs.sv */
// ============================================================================
// nnsg_regs: configuration register file
// APB-style slave holding the frame sizes and the number of glyph levels.
// ============================================================================
`default_nettype none

module nnsg_regs
    import nnsg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output nnsg_cfg_t                  cfg
);

    nnsg_cfg_t  cfg_reg, cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write decode; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_SRC_WIDTH:    cfg_next.src_width    = pwdata[REG_W-1:0];
                REG_SRC_HEIGHT:   cfg_next.src_height   = pwdata[REG_W-1:0];
                REG_OUT_WIDTH:    cfg_next.out_width    = pwdata[REG_W-1:0];
                REG_OUT_HEIGHT:   cfg_next.out_height   = pwdata[REG_W-1:0];
                REG_GLYPH_LEVELS: cfg_next.glyph_levels = pwdata[REG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width    <= RST_SRC_WIDTH;
            cfg_reg.src_height   <= RST_SRC_HEIGHT;
            cfg_reg.out_width    <= RST_OUT_WIDTH;
            cfg_reg.out_height   <= RST_OUT_HEIGHT;
            cfg_reg.glyph_levels <= RST_GLYPH_LEVELS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (index)
            REG_SRC_WIDTH:    prdata = APB_DATA_W'(cfg_reg.src_width);
            REG_SRC_HEIGHT:   prdata = APB_DATA_W'(cfg_reg.src_height);
            REG_OUT_WIDTH:    prdata = APB_DATA_W'(cfg_reg.out_width);
            REG_OUT_HEIGHT:   prdata = APB_DATA_W'(cfg_reg.out_height);
            REG_GLYPH_LEVELS: prdata = APB_DATA_W'(cfg_reg.glyph_levels);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/nearest_neighbor_scale_to_glyph_level_unit.sv */
// ============================================================================
// nearest_neighbor_scale_to_glyph_level_unit: scaler and glyph quantizer
// Stores a grayscale source frame and returns nearest-neighbor samples of a
// scaled image together with their brightness level.
// ============================================================================
// A command is taken when start is high and busy is low. A pixel write inside
// the source size gives no result and does not raise busy, so the next command
// may follow at once. A command outside the configured size gives a result with
// range_error set in the next cycle, also without raising busy. A fetch inside
// the output size keeps busy high while two bit-serial dividers run side by
// side for nine steps to map the column and row onto the source frame, then
// a frame store read, a multiply by the level count minus one and a
// reciprocal scale by 255 follow. Each result is shown for exactly one cycle
// on result, marked by result_valid, and cannot be held off. The frame store
// is not cleared after reset; fetch only positions that were written.
// ============================================================================
`default_nettype none

module nearest_neighbor_scale_to_glyph_level_unit
    import nnsg_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire nnsg_item_t            command,
    output logic                       result_valid,
    output nnsg_result_t               result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REG_MAX  = (1 << REG_W) - 1;
    localparam int SW_LIMIT = (MAX_SRC_WIDTH > REG_MAX) ? REG_MAX : MAX_SRC_WIDTH;
    localparam int SH_LIMIT = (MAX_SRC_HEIGHT > REG_MAX) ? REG_MAX : MAX_SRC_HEIGHT;
    localparam int DVD_W    = 8 + REG_W;
    localparam int PROD_W   = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LEVEL
    } state_t;

    state_t           state_reg;
    nnsg_result_t     result_reg;
    logic             result_valid_reg;
    logic [7:0]       sample_reg;
    logic [PROD_W-1:0] prod_reg;

    nnsg_cfg_t        cfg;
    logic [REG_W-1:0] sw, sh, ow, oh, lv;
    logic [7:0]       lv_m1;
    logic             accept;
    logic             write_ok, write_bad, fetch_ok, fetch_bad;
    logic             ram_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]       rdata;
    logic [DVD_W-1:0] dvd_x, dvd_y;
    logic             div_start;
    logic             done_x, done_y;
    logic [REG_W-1:0] quo_x, quo_y;
    logic [PROD_W-1:0] level_sum;

    // Configuration registers.
    nnsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Effective sizes: zero acts as one, oversize source sizes and level counts saturate.
    always_comb
    begin
        sw = cfg.src_width;
        if (cfg.src_width == '0)
        begin
            sw = REG_W'(1);
        end
        else if (32'(cfg.src_width) > SW_LIMIT)
        begin
            sw = REG_W'(SW_LIMIT);
        end
        sh = cfg.src_height;
        if (cfg.src_height == '0)
        begin
            sh = REG_W'(1);
        end
        else if (32'(cfg.src_height) > SH_LIMIT)
        begin
            sh = REG_W'(SH_LIMIT);
        end
        ow = (cfg.out_width == '0) ? REG_W'(1) : cfg.out_width;
        oh = (cfg.out_height == '0) ? REG_W'(1) : cfg.out_height;
        lv = cfg.glyph_levels;
        if (cfg.glyph_levels == '0)
        begin
            lv = REG_W'(1);
        end
        else if (cfg.glyph_levels > LEVEL_LIMIT)
        begin
            lv = LEVEL_LIMIT;
        end
    end

    assign lv_m1 = 8'(lv - 1'b1);

    // Command decode and range checks.
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign write_ok  = accept && (command.cmd == CMD_WRITE)
                       && ({1'b0, command.col} < sw) && ({1'b0, command.row} < sh);
    assign write_bad = accept && (command.cmd == CMD_WRITE) && !write_ok;
    assign fetch_ok  = accept && (command.cmd == CMD_FETCH)
                       && ({1'b0, command.col} < ow) && ({1'b0, command.row} < oh);
    assign fetch_bad = accept && (command.cmd == CMD_FETCH) && !fetch_ok;
    assign div_start = fetch_ok;

    // Frame store, addressed row * MAX_SRC_WIDTH + col.
    assign ram_we = write_ok;
    assign waddr  = ADDR_W'(32'(command.row) * MAX_SRC_WIDTH + 32'(command.col));
    assign raddr  = ADDR_W'(32'(quo_y) * MAX_SRC_WIDTH + 32'(quo_x));

    nnsg_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (command.pixel_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Coordinate mapping: col * sw / ow and row * sh / oh, one bit a cycle.
    assign dvd_x = DVD_W'(command.col) * DVD_W'(sw);
    assign dvd_y = DVD_W'(command.row) * DVD_W'(sh);

    nnsg_divider #(
        .DVD_W (DVD_W),
        .DVS_W (REG_W),
        .QUO_W (REG_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (ow),
        .done     (done_x),
        .quotient (quo_x)
    );

    nnsg_divider #(
        .DVD_W (DVD_W),
        .DVS_W (REG_W),
        .QUO_W (REG_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (oh),
        .done     (done_y),
        .quotient (quo_y)
    );

    // Division by 255 for products below 65280: (p + (p >> 8) + 1) >> 8.
    assign level_sum = prod_reg + (prod_reg >> 8) + PROD_W'(1);

    // Sequencer with the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            sample_reg       <= '0;
            prod_reg         <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (write_bad || fetch_bad)
                    begin
                        result_valid_reg       <= 1'b1;
                        result_reg.sample      <= '0;
                        result_reg.level_index <= '0;
                        result_reg.range_error <= 1'b1;
                    end
                    if (fetch_ok)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    // Both dividers finish together; the read is issued now.
                    if (done_x && done_y)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    sample_reg <= rdata;
                    prod_reg   <= PROD_W'(rdata) * PROD_W'(lv_m1);
                    state_reg  <= ST_LEVEL;
                end
                ST_LEVEL:
                begin
                    result_valid_reg       <= 1'b1;
                    result_reg.sample      <= sample_reg;
                    result_reg.level_index <= level_sum[15:8];
                    result_reg.range_error <= 1'b0;
                    state_reg              <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* rtl/nnsg_checker.sv */
// ============================================================================
// nnsg_checker: port-level checks for the scale-to-glyph-level unit
// Watches the command and result transfers over time and is bound to the
// top level.
// ============================================================================
`default_nettype none

module nnsg_checker
    import nnsg_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire nnsg_item_t   command,
    input wire logic         result_valid,
    input wire nnsg_result_t result
);

    // A rejected coordinate carries no sample and no level.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.range_error |->
            (result.sample == 8'd0) && (result.level_index == 8'd0))
        else $error("range error result carries data");

    // An accepted fetch either starts work or reports an error next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command.cmd == CMD_FETCH) |=> busy || result_valid)
        else $error("fetch transfer vanished");

    // A result only follows an accepted command or a running fetch.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start && !busy))
        else $error("result without a command");

    // A fetch in progress ends with its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    // The level never exceeds the sample it was derived from.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.level_index <= result.sample)
        else $error("level above sample");

endmodule

bind nearest_neighbor_scale_to_glyph_level_unit nnsg_checker u_checker (.*);

`default_nettype wire
